// File: sv/tono_pkg.sv
// shared types, constants and reply selection for the telnet option negotiator
package tono_pkg;

  localparam int OPTION_COUNT = 256;
  localparam int IDX_W        = $clog2(OPTION_COUNT);

  typedef enum logic [1:0] {
    CMD_WILL = 2'd0,
    CMD_WONT = 2'd1,
    CMD_DO   = 2'd2,
    CMD_DONT = 2'd3
  } cmd_t;

  localparam logic [7:0] OPT_BINARY   = 8'd0;
  localparam logic [7:0] OPT_TERM_ID  = 8'd24;
  localparam logic [7:0] OPT_REC_END  = 8'd25;
  localparam logic [7:0] OPT_ENV_VARS = 8'd39;

  typedef struct packed {
    logic       enabled;
    logic [3:0] marks;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  function automatic logic is_supported(input logic [7:0] opt);
    return (opt == OPT_BINARY) || (opt == OPT_TERM_ID) ||
           (opt == OPT_REC_END) || (opt == OPT_ENV_VARS);
  endfunction

  function automatic cmd_t choose_reply(input cmd_t cmd, input logic supported);
    cmd_t reply;
    case (cmd)
      CMD_WILL: reply = supported ? CMD_DO : CMD_DONT;
      CMD_WONT: reply = CMD_DONT;
      CMD_DO:   reply = supported ? CMD_WILL : CMD_WONT;
      default:  reply = CMD_WONT;
    endcase
    return reply;
  endfunction

endpackage

// File: sv/tono_if.sv
// valid/ready channels for received commands and transmitted replies
interface tono_cmd_if;
  logic                valid;
  logic                ready;
  tono_pkg::cmd_t      cmd;
  logic [7:0]          option_code;

  modport source (output valid, output cmd, output option_code, input ready);
  modport sink   (input valid, input cmd, input option_code, output ready);
endinterface

interface tono_reply_if;
  logic                valid;
  logic                ready;
  tono_pkg::cmd_t      reply_cmd;
  logic [7:0]          reply_option;

  modport source (output valid, output reply_cmd, output reply_option, input ready);
  modport sink   (input valid, input reply_cmd, input reply_option, output ready);
endinterface

// File: sv/tono_mem.sv
// per-option state memory with valid bits so unwritten entries read as zero
module tono_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  tono_pkg::mem_req_t req,
  output tono_pkg::entry_t   rd_data
);

  tono_pkg::entry_t                  mem [tono_pkg::OPTION_COUNT];
  logic [tono_pkg::OPTION_COUNT-1:0] valid_r;
  tono_pkg::entry_t                  rd_raw_r;
  logic                              rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule

// File: sv/tono_ctrl.sv
// command sequencer: read entry, decide reply, write back, hold result beat
module tono_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  tono_cmd_if.sink           in_ch,
  tono_reply_if.source       out_ch,
  output tono_pkg::mem_req_t req,
  input  tono_pkg::entry_t   rd_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_t;

  state_t         state_r;
  tono_pkg::cmd_t cmd_r;
  logic [7:0]     opt_r;
  logic           out_valid_r;
  tono_pkg::cmd_t out_cmd_r;
  logic [7:0]     out_opt_r;

  logic             stored;
  tono_pkg::entry_t cur_entry;
  logic             drop;
  tono_pkg::cmd_t   reply;
  logic [3:0]       bit_sel;
  logic             emit;
  logic             can_finish;
  logic             finish_emit;
  tono_pkg::entry_t new_entry;

  always_comb begin
    stored            = ({1'b0, opt_r} < 9'(tono_pkg::OPTION_COUNT));
    // options beyond the table read as disabled with no marks
    cur_entry.enabled = stored && rd_data.enabled;
    cur_entry.marks   = stored ? rd_data.marks : 4'b0000;
    drop       = ((cmd_r == tono_pkg::CMD_DO) && cur_entry.enabled) ||
                 ((cmd_r == tono_pkg::CMD_DONT) && !cur_entry.enabled);
    reply      = tono_pkg::choose_reply(cmd_r, tono_pkg::is_supported(opt_r));
    bit_sel    = 4'b0001 << reply;
    emit       = !drop && ((cur_entry.marks & bit_sel) == 4'b0000);
    can_finish = !out_valid_r || out_ch.ready;
    finish_emit = (state_r == ST_EVAL) && can_finish && emit;
    new_entry.marks = cur_entry.marks ^ bit_sel;
    case (cmd_r)
      tono_pkg::CMD_DO:   new_entry.enabled = 1'b1;
      tono_pkg::CMD_DONT: new_entry.enabled = 1'b0;
      default:            new_entry.enabled = cur_entry.enabled;
    endcase
  end

  always_comb begin
    req.rd_en   = (state_r == ST_IDLE) && in_ch.valid;
    req.rd_addr = in_ch.option_code[tono_pkg::IDX_W-1:0];
    req.wr_en   = (state_r == ST_EVAL) && can_finish && stored && !drop;
    req.wr_addr = opt_r[tono_pkg::IDX_W-1:0];
    req.wr_data = new_entry;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.reply_cmd    = out_cmd_r;
  assign out_ch.reply_option = out_opt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (finish_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.cmd;
            opt_r   <= in_ch.option_code;
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (can_finish) begin
            if (emit) begin
              out_cmd_r <= reply;
              out_opt_r <= opt_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/telnet_option_negotiator_unit.sv
// top level of the telnet option negotiator
// a command beat taken in ST_IDLE starts the read of the per-option state memory;
//   ST_EVAL then registers any reply beat and writes back, and only after that is
//   the next command taken; a stalled reply holds the block in ST_EVAL
// reset: synchronous active-low rst_n clears control state and all valid bits
//   at once, so every option reads as disabled with no marks; no clearing pass
module telnet_option_negotiator_unit (
  input  logic         clk,
  input  logic         rst_n,
  tono_cmd_if.sink     in_ch,
  tono_reply_if.source out_ch
);

  tono_pkg::mem_req_t req;
  tono_pkg::entry_t   rd_data;

  tono_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (req),
    .rd_data (rd_data)
  );

  tono_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// File: tb/telnet_option_negotiator_unit_checker.sv
// reply predictor and scoreboard for the telnet option negotiator
`timescale 1ns / 1ps

module telnet_option_negotiator_unit_checker (
  input  logic  clk,
  input  logic  rst_n,
  tono_cmd_if   cmd_bus,
  tono_reply_if reply_bus,
  input  logic  drain_check,
  output int    fail_count,
  output int    pending_replies
);

  typedef struct packed {
    tono_pkg::cmd_t reply_cmd;
    logic [7:0]     reply_option;
  } reply_beat_t;

  logic        option_on   [tono_pkg::OPTION_COUNT];
  logic [3:0]  reply_marks [tono_pkg::OPTION_COUNT];
  reply_beat_t expected_replies [$];

  initial begin
    fail_count      = 0;
    pending_replies = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void negotiate(input tono_pkg::cmd_t rx_cmd, input logic [7:0] opt);
    logic           in_table;
    logic           on;
    logic [3:0]     marks;
    logic           known;
    tono_pkg::cmd_t reply;
    in_table = (opt < tono_pkg::OPTION_COUNT);
    on       = in_table ? option_on[opt] : 1'b0;
    marks    = in_table ? reply_marks[opt] : 4'd0;
    known    = opt inside {tono_pkg::OPT_BINARY, tono_pkg::OPT_TERM_ID,
                           tono_pkg::OPT_REC_END, tono_pkg::OPT_ENV_VARS};
    // redundant requests are dropped without touching state
    if ((rx_cmd == tono_pkg::CMD_DO && on) || (rx_cmd == tono_pkg::CMD_DONT && !on)) return;
    case (rx_cmd)
      tono_pkg::CMD_WILL: reply = known ? tono_pkg::CMD_DO : tono_pkg::CMD_DONT;
      tono_pkg::CMD_WONT: reply = tono_pkg::CMD_DONT;
      tono_pkg::CMD_DO:   reply = known ? tono_pkg::CMD_WILL : tono_pkg::CMD_WONT;
      default:            reply = tono_pkg::CMD_WONT;
    endcase
    // a reply already marked as sent is swallowed and its mark cleared
    if (marks[reply]) begin
      marks[reply] = 1'b0;
    end else begin
      marks[reply] = 1'b1;
      expected_replies.push_back(reply_beat_t'{reply, opt});
    end
    if (in_table) begin
      reply_marks[opt] = marks;
      if (rx_cmd == tono_pkg::CMD_DO) option_on[opt] = 1'b1;
      else if (rx_cmd == tono_pkg::CMD_DONT) option_on[opt] = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    reply_beat_t want;
    if (!rst_n) begin
      foreach (option_on[i]) begin
        option_on[i]   = 1'b0;
        reply_marks[i] = 4'd0;
      end
      expected_replies.delete();
    end else begin
      if (reply_bus.valid && reply_bus.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply beat cmd %0d option %0d",
                                    reply_bus.reply_cmd, reply_bus.reply_option));
        end else begin
          want = expected_replies.pop_front();
          if (reply_bus.reply_cmd !== want.reply_cmd)
            report_mismatch($sformatf("reply_cmd %0d, expected %0d (option %0d)",
                                      reply_bus.reply_cmd, want.reply_cmd,
                                      want.reply_option));
          if (reply_bus.reply_option !== want.reply_option)
            report_mismatch($sformatf("reply_option %0d, expected %0d",
                                      reply_bus.reply_option, want.reply_option));
        end
      end
      if (cmd_bus.valid && cmd_bus.ready)
        negotiate(cmd_bus.cmd, cmd_bus.option_code);
    end
    pending_replies <= expected_replies.size();
  end

  always @(posedge drain_check) begin
    if (expected_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
  end

endmodule

// File: tb/telnet_option_negotiator_unit_tb.sv
// stimulus, clock, reset and verdict for the telnet option negotiator
`timescale 1ns / 1ps

module telnet_option_negotiator_unit_tb;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 8;

  logic clk;
  logic rst_n;
  logic drain_check;
  logic idle_on;
  logic hold_off_request;
  int   fail_count;
  int   pending_replies;

  tono_cmd_if   cmd_ch ();
  tono_reply_if reply_ch ();

  telnet_option_negotiator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (reply_ch)
  );

  telnet_option_negotiator_unit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_bus         (cmd_ch),
    .reply_bus       (reply_ch),
    .drain_check     (drain_check),
    .fail_count      (fail_count),
    .pending_replies (pending_replies)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    reply_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        reply_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        reply_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input tono_pkg::cmd_t c, input logic [7:0] opt);
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= c;
    cmd_ch.option_code <= opt;
    do @(posedge clk); while (!cmd_ch.ready);
    sender_gap();
  endtask

  task automatic wait_replies_done();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_replies != 0);
  endtask

  // bias toward a few options so the enabled bits and marks get exercised
  function automatic logic [7:0] pick_option();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      case ($urandom_range(0, 3))
        0:       return tono_pkg::OPT_BINARY;
        1:       return tono_pkg::OPT_TERM_ID;
        2:       return tono_pkg::OPT_REC_END;
        default: return tono_pkg::OPT_ENV_VARS;
      endcase
    end
    if (sel < 8) begin
      case ($urandom_range(0, 3))
        0:       return 8'd1;
        1:       return 8'd3;
        2:       return 8'd254;
        default: return 8'd255;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_cmd(tono_pkg::cmd_t'($urandom_range(0, 3)), pick_option());
  endtask

  initial begin
    rst_n              <= 1'b0;
    drain_check         = 1'b0;
    idle_on             = 1'b1;
    hold_off_request    = 1'b0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.cmd         <= tono_pkg::CMD_WILL;
    cmd_ch.option_code <= 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: supported and unsupported, repeats, drops, extreme options
    send_cmd(tono_pkg::CMD_WILL, tono_pkg::OPT_BINARY);
    send_cmd(tono_pkg::CMD_WILL, tono_pkg::OPT_BINARY);
    send_cmd(tono_pkg::CMD_WILL, tono_pkg::OPT_BINARY);
    send_cmd(tono_pkg::CMD_WONT, tono_pkg::OPT_BINARY);
    send_cmd(tono_pkg::CMD_DO,   tono_pkg::OPT_TERM_ID);
    send_cmd(tono_pkg::CMD_DO,   tono_pkg::OPT_TERM_ID);
    send_cmd(tono_pkg::CMD_DONT, tono_pkg::OPT_TERM_ID);
    send_cmd(tono_pkg::CMD_DONT, tono_pkg::OPT_TERM_ID);
    send_cmd(tono_pkg::CMD_DO,   tono_pkg::OPT_REC_END);
    send_cmd(tono_pkg::CMD_DO,   tono_pkg::OPT_ENV_VARS);
    send_cmd(tono_pkg::CMD_DO,   8'd7);
    send_cmd(tono_pkg::CMD_DONT, 8'd7);
    send_cmd(tono_pkg::CMD_WILL, 8'd255);
    send_cmd(tono_pkg::CMD_WONT, 8'd255);
    send_cmd(tono_pkg::CMD_WONT, 8'd255);
    send_cmd(tono_pkg::CMD_DO,   8'd255);
    send_cmd(tono_pkg::CMD_DO,   8'd128);
    send_cmd(tono_pkg::CMD_WILL, 8'd170);
    send_cmd(tono_pkg::CMD_WILL, 8'd85);
    send_cmd(tono_pkg::CMD_DONT, tono_pkg::OPT_BINARY);
    send_cmd(tono_pkg::CMD_DONT, 8'd255);
    send_cmd(tono_pkg::CMD_WILL, tono_pkg::OPT_ENV_VARS);

    send_random(150);

    // receiver holds off while commands keep coming
    hold_off_request = 1'b1;
    idle_on          = 1'b0;
    send_random(30);
    idle_on          = 1'b1;

    wait_replies_done();
    send_random(170);

    // closing stretch with no idling on either side
    idle_on = 1'b0;
    send_random(100);

    wait_replies_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain_check = 1'b1;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
